// ===== hw/rtl/clba_pkg.sv =====
// shared types and constants for the checkpoint boundary aligner
// used by every module of the block; no dependencies
`default_nettype none

package clba_pkg;

  localparam int TOKEN_BITS_DEF = 20;
  localparam int BLOCK_BITS_DEF = 16;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_LOOKUP = 2'd0,
    CFG_CACHE  = 2'd1,
    CFG_MODE   = 2'd2,
    CFG_BLOCK  = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GCD_EVEN,
    ST_GCD,
    ST_DIV,
    ST_MUL,
    ST_RANGE,
    ST_MOD,
    ST_CAND,
    ST_CMP,
    ST_DONE
  } seq_state_e;

  typedef struct packed {
    logic lookup_supported;
    logic cache_on;
    logic reusable_mode;
  } cfg_flags_t;

  typedef struct packed {
    logic idle;
    logic done;
  } seq_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/clba_alu.sv =====
// shared add/subtract unit with borrow flag
// depends on clba_pkg for the operation code
`default_nettype none

module clba_alu #(
  parameter int WIDTH = clba_pkg::TOKEN_BITS_DEF + clba_pkg::BLOCK_BITS_DEF
) (
  input  logic [WIDTH-1:0]   a_i,
  input  logic [WIDTH-1:0]   b_i,
  input  clba_pkg::alu_op_e  op_i,
  output logic [WIDTH-1:0]   res_o,
  output logic               borrow_o
);
  import clba_pkg::*;

  logic             is_sub;
  logic [WIDTH-1:0] b_eff;
  logic [WIDTH:0]   sum;

  assign is_sub   = (op_i == ALU_SUB);
  assign b_eff    = is_sub ? ~b_i : b_i;
  // single adder, subtraction as a + ~b + 1
  assign sum      = {1'b0, a_i} + {1'b0, b_eff} + {{WIDTH{1'b0}}, is_sub};
  assign res_o    = sum[WIDTH-1:0];
  assign borrow_o = is_sub & ~sum[WIDTH];

endmodule

`default_nettype wire

// ===== hw/rtl/clba_seq.sv =====
// sequencer and datapath registers: binary gcd, divide, multiply, modulo
// depends on clba_pkg and drives one clba_alu for every arithmetic step
`default_nettype none

module clba_seq #(
  parameter int TOKEN_BITS = clba_pkg::TOKEN_BITS_DEF,
  parameter int BLOCK_BITS = clba_pkg::BLOCK_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  clba_pkg::cfg_flags_t  flags_i,
  input  logic [BLOCK_BITS-1:0] blk_i,
  input  logic                  start_i,
  input  logic [TOKEN_BITS-1:0] prompt_i,
  input  logic [TOKEN_BITS-1:0] restored_i,
  input  logic [TOKEN_BITS-1:0] segment_i,
  input  logic                  out_free_i,
  output clba_pkg::seq_stat_t   stat_o,
  output logic                  res_valid_o,
  output logic [TOKEN_BITS-1:0] res_bound_o
);
  import clba_pkg::*;

  localparam int XW = TOKEN_BITS + BLOCK_BITS;
  localparam int GW = (TOKEN_BITS > BLOCK_BITS) ? TOKEN_BITS : BLOCK_BITS;
  localparam int KW = $clog2(BLOCK_BITS);
  localparam int CW = $clog2(GW);

  seq_state_e state_q, state_d;

  logic [TOKEN_BITS-1:0] pm1_q, pm1_d;
  logic [TOKEN_BITS-1:0] rsv_q, rsv_d;
  logic [TOKEN_BITS-1:0] seg_q, seg_d;
  logic [GW-1:0]         ga_q, ga_d;
  logic [GW-1:0]         gb_q, gb_d;
  logic [KW-1:0]         k_q, k_d;
  logic [BLOCK_BITS-1:0] g_q, g_d;
  logic [GW-1:0]         dvd_q, dvd_d;
  logic [GW-1:0]         quo_q, quo_d;
  logic [GW-1:0]         r_q, r_d;
  logic [XW-1:0]         acc_q, acc_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic                  res_valid_q, res_valid_d;
  logic [TOKEN_BITS-1:0] res_bound_q, res_bound_d;

  logic [XW-1:0] alu_a, alu_b, alu_res;
  alu_op_e       alu_op;
  logic          alu_borrow;
  logic          en;

  clba_alu #(
    .WIDTH(XW)
  ) u_alu (
    .a_i     (alu_a),
    .b_i     (alu_b),
    .op_i    (alu_op),
    .res_o   (alu_res),
    .borrow_o(alu_borrow)
  );

  assign en = flags_i.lookup_supported & flags_i.cache_on & flags_i.reusable_mode &
              (blk_i != '0) & (prompt_i != '0);

  always_comb begin
    state_d     = state_q;
    pm1_d       = pm1_q;
    rsv_d       = rsv_q;
    seg_d       = seg_q;
    ga_d        = ga_q;
    gb_d        = gb_q;
    k_d         = k_q;
    g_d         = g_q;
    dvd_d       = dvd_q;
    quo_d       = quo_q;
    r_d         = r_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    res_valid_d = res_valid_q;
    res_bound_d = res_bound_q;
    alu_a       = '0;
    alu_b       = '0;
    alu_op      = ALU_SUB;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          pm1_d = prompt_i - TOKEN_BITS'(1);
          rsv_d = restored_i;
          seg_d = segment_i;
          if (!en) begin
            res_valid_d = 1'b0;
            res_bound_d = '0;
            state_d     = ST_DONE;
          end else if (segment_i == '0) begin
            acc_d   = XW'(blk_i);
            state_d = ST_RANGE;
          end else begin
            ga_d    = GW'(blk_i);
            gb_d    = GW'(segment_i);
            k_d     = '0;
            state_d = ST_GCD_EVEN;
          end
        end
      end

      // strip common factors of two
      ST_GCD_EVEN: begin
        if (!ga_q[0] && !gb_q[0]) begin
          ga_d = ga_q >> 1;
          gb_d = gb_q >> 1;
          k_d  = k_q + KW'(1);
        end else begin
          state_d = ST_GCD;
        end
      end

      ST_GCD: begin
        alu_a = XW'(ga_q);
        alu_b = XW'(gb_q);
        if (ga_q == '0) begin
          g_d     = BLOCK_BITS'(gb_q << k_q);
          dvd_d   = GW'(blk_i) << (GW - BLOCK_BITS);
          r_d     = '0;
          quo_d   = '0;
          cnt_d   = CW'(BLOCK_BITS - 1);
          state_d = ST_DIV;
        end else if (!ga_q[0]) begin
          ga_d = ga_q >> 1;
        end else if (!gb_q[0]) begin
          gb_d = gb_q >> 1;
        end else if (alu_borrow) begin
          // keep the larger odd value in ga
          ga_d = gb_q;
          gb_d = ga_q;
        end else begin
          ga_d = alu_res[GW-1:0];
        end
      end

      // block / gcd, one quotient bit a cycle
      ST_DIV: begin
        alu_a = XW'({r_q, dvd_q[GW-1]});
        alu_b = XW'(g_q);
        r_d   = alu_borrow ? alu_a[GW-1:0] : alu_res[GW-1:0];
        quo_d = {quo_q[GW-2:0], ~alu_borrow};
        dvd_d = dvd_q << 1;
        if (cnt_q == '0) begin
          acc_d   = '0;
          cnt_d   = CW'(BLOCK_BITS - 1);
          state_d = ST_MUL;
        end else begin
          cnt_d = cnt_q - CW'(1);
        end
      end

      // quotient * segment, shift-add from the msb
      ST_MUL: begin
        alu_op = ALU_ADD;
        alu_a  = acc_q << 1;
        alu_b  = quo_q[BLOCK_BITS-1] ? XW'(seg_q) : '0;
        acc_d  = alu_res;
        quo_d  = quo_q << 1;
        if (cnt_q == '0) begin
          state_d = ST_RANGE;
        end else begin
          cnt_d = cnt_q - CW'(1);
        end
      end

      // alignment above prompt-1 gives a zero boundary
      ST_RANGE: begin
        alu_a = XW'(pm1_q);
        alu_b = acc_q;
        if (alu_borrow) begin
          res_valid_d = 1'b0;
          res_bound_d = '0;
          state_d     = ST_DONE;
        end else begin
          dvd_d   = GW'(pm1_q) << (GW - TOKEN_BITS);
          r_d     = '0;
          cnt_d   = CW'(TOKEN_BITS - 1);
          state_d = ST_MOD;
        end
      end

      ST_MOD: begin
        alu_a = XW'({r_q, dvd_q[GW-1]});
        alu_b = acc_q;
        r_d   = alu_borrow ? alu_a[GW-1:0] : alu_res[GW-1:0];
        dvd_d = dvd_q << 1;
        if (cnt_q == '0) begin
          state_d = ST_CAND;
        end else begin
          cnt_d = cnt_q - CW'(1);
        end
      end

      ST_CAND: begin
        alu_a   = XW'(pm1_q);
        alu_b   = XW'(r_q);
        r_d     = alu_res[GW-1:0];
        state_d = ST_CMP;
      end

      // valid only when restored < candidate
      ST_CMP: begin
        alu_a       = XW'(rsv_q);
        alu_b       = XW'(r_q);
        res_valid_d = alu_borrow;
        res_bound_d = alu_borrow ? r_q[TOKEN_BITS-1:0] : '0;
        state_d     = ST_DONE;
      end

      ST_DONE: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pm1_q       <= pm1_d;
    rsv_q       <= rsv_d;
    seg_q       <= seg_d;
    ga_q        <= ga_d;
    gb_q        <= gb_d;
    k_q         <= k_d;
    g_q         <= g_d;
    dvd_q       <= dvd_d;
    quo_q       <= quo_d;
    r_q         <= r_d;
    acc_q       <= acc_d;
    cnt_q       <= cnt_d;
    res_valid_q <= res_valid_d;
    res_bound_q <= res_bound_d;
  end

  assign stat_o.idle = (state_q == ST_IDLE);
  assign stat_o.done = (state_q == ST_DONE);
  assign res_valid_o = res_valid_q;
  assign res_bound_o = res_bound_q;

endmodule

`default_nettype wire

// ===== hw/rtl/checkpoint_boundary_lcm_align.sv =====
// with no segment, a word goes through range check, modulo, candidate and compare to the
// output register, skipping steps when the alignment exceeds prompt-1 or the block is off;
// with a segment, the binary gcd, divide and multiply come first, all on one shared adder
// throughput: one word at a time, input not ready until the result is in the output register
// reset: async active low; config registers clear to 0, sequencer idles, output empty
`default_nettype none

module checkpoint_boundary_lcm_align #(
  parameter int TOKEN_BITS = clba_pkg::TOKEN_BITS_DEF,
  parameter int BLOCK_BITS = clba_pkg::BLOCK_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [1:0]                             cfg_idx_i,
  input  logic [BLOCK_BITS-1:0]                  cfg_data_i,
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // prompt_tokens, restored_count, segment_tokens
  input  logic [((3*TOKEN_BITS+7)/8)*8-1:0]      s_axis_tdata_i,
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  // boundary_tokens
  output logic [((TOKEN_BITS+7)/8)*8-1:0]        m_axis_tdata_o,
  // checkpoint_valid
  output logic                                   m_axis_tuser_o
);
  import clba_pkg::*;

  localparam int OUT_DW = ((TOKEN_BITS + 7) / 8) * 8;

  cfg_flags_t            flags_q, flags_d;
  logic [BLOCK_BITS-1:0] blk_q, blk_d;

  seq_stat_t             stat;
  logic                  start;
  logic                  out_free;
  logic                  res_valid;
  logic [TOKEN_BITS-1:0] res_bound;

  logic                  m_valid_q;
  logic [OUT_DW-1:0]     m_data_q;
  logic                  m_user_q;

  always_comb begin
    flags_d = flags_q;
    blk_d   = blk_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_LOOKUP: flags_d.lookup_supported = cfg_data_i[0];
        CFG_CACHE:  flags_d.cache_on         = cfg_data_i[0];
        CFG_MODE:   flags_d.reusable_mode    = cfg_data_i[0];
        CFG_BLOCK:  blk_d                    = cfg_data_i;
        default: begin
          blk_d = blk_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
      blk_q   <= '0;
    end else begin
      flags_q <= flags_d;
      blk_q   <= blk_d;
    end
  end

  assign s_axis_tready_o = stat.idle;
  assign start           = s_axis_tvalid_i & stat.idle;
  assign out_free        = ~m_valid_q | m_axis_tready_i;

  clba_seq #(
    .TOKEN_BITS(TOKEN_BITS),
    .BLOCK_BITS(BLOCK_BITS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .flags_i    (flags_q),
    .blk_i      (blk_q),
    .start_i    (start),
    .prompt_i   (s_axis_tdata_i[TOKEN_BITS-1:0]),
    .restored_i (s_axis_tdata_i[2*TOKEN_BITS-1:TOKEN_BITS]),
    .segment_i  (s_axis_tdata_i[3*TOKEN_BITS-1:2*TOKEN_BITS]),
    .out_free_i (out_free),
    .stat_o     (stat),
    .res_valid_o(res_valid),
    .res_bound_o(res_bound)
  );

  // output register, loaded when the sequencer finishes and the slot is free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (stat.done && out_free) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat.done && out_free) begin
      m_data_q <= OUT_DW'(res_bound);
      m_user_q <= res_valid;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

endmodule

`default_nettype wire

// ===== hw/rtl/clba_chk.sv =====
// port-level checker for the checkpoint boundary aligner, bound to the top level
// depends on checkpoint_boundary_lcm_align port list and clba_pkg defaults
`default_nettype none

module clba_chk #(
  parameter int TOKEN_BITS = clba_pkg::TOKEN_BITS_DEF
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid_i,
  input logic                              s_axis_tready_o,
  input logic                              m_axis_tvalid_o,
  input logic                              m_axis_tready_i,
  input logic [((TOKEN_BITS+7)/8)*8-1:0]   m_axis_tdata_o,
  input logic                              m_axis_tuser_o
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("output word changed while stalled");

  // one word in flight: busy right after an accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted while busy");

  // no checkpoint means a zero boundary, a checkpoint means a nonzero one
  a_zero_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o == (m_axis_tdata_o != '0)))
    else $error("boundary does not match checkpoint flag");

  // a new result only comes from a finished, busy sequencer
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> !$past(s_axis_tready_o))
    else $error("result appeared without a busy sequencer");

endmodule

bind checkpoint_boundary_lcm_align clba_chk #(
  .TOKEN_BITS(TOKEN_BITS)
) u_clba_chk (.*);

`default_nettype wire

// ===== test/checkpoint_boundary_lcm_align_tb.sv =====
// self-checking bench for the checkpoint boundary aligner: directed table, then random phases
// depends on clba_pkg and checkpoint_boundary_lcm_align
`timescale 1ns / 100ps

module checkpoint_boundary_lcm_align_tb;
  import clba_pkg::*;

  localparam int TOKEN_BITS   = clba_pkg::TOKEN_BITS_DEF;
  localparam int BLOCK_BITS   = clba_pkg::BLOCK_BITS_DEF;
  localparam int IN_W         = ((3*TOKEN_BITS+7)/8)*8;
  localparam int OUT_W        = ((TOKEN_BITS+7)/8)*8;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 120;
  localparam int HOLD_AT      = 600;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = 200;
  localparam int IDLE_LIMIT   = 2000;

  typedef logic [TOKEN_BITS-1:0] token_t;
  typedef logic [BLOCK_BITS-1:0] block_t;

  typedef struct packed {
    logic   valid;
    token_t boundary;
  } checkpoint_t;

  typedef struct packed {
    logic   lookup;
    logic   cache;
    logic   mode;
    block_t blk;
    token_t prompt;
    token_t restored;
    token_t segment;
    logic   typed;
    logic   want_valid;
    token_t want_boundary;
  } dir_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_idx_i = CFG_LOOKUP;
  logic [BLOCK_BITS-1:0] cfg_data_i = '0;
  logic               s_axis_tvalid_i = 1'b0;
  logic               s_axis_tready_o;
  logic [IN_W-1:0]    s_axis_tdata_i = '0;  // prompt_tokens, restored_count, segment_tokens
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i = 1'b0;
  logic [OUT_W-1:0]   m_axis_tdata_o;       // boundary_tokens
  logic               m_axis_tuser_o;       // checkpoint_valid

  checkpoint_boundary_lcm_align #(
    .TOKEN_BITS(TOKEN_BITS),
    .BLOCK_BITS(BLOCK_BITS)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i(s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o(m_axis_tdata_o),
    .m_axis_tuser_o(m_axis_tuser_o)
  );

  // local copy of the register file
  logic   lookup_en = 1'b0;
  logic   cache_en  = 1'b0;
  logic   reuse_mode = 1'b0;
  block_t blk_tokens = '0;

  checkpoint_t pending_checkpoints[$];
  int mismatches = 0;
  int words_in = 0;
  int words_out = 0;
  int checkpoints_seen = 0;
  int settings_used = 0;
  bit tx_gaps = 1'b1;
  bit rx_gaps = 1'b1;

  dir_row_t dir_rows [25] = '{
    // after reset every register is clear
    '{1'b0, 1'b0, 1'b0, 16'd0, 20'd100, 20'd0, 20'd0, 1'b1, 1'b0, 20'd0},
    '{1'b0, 1'b0, 1'b0, 16'd0, 20'hFFFFF, 20'd0, 20'hFFFFF, 1'b1, 1'b0, 20'd0},
    '{1'b1, 1'b1, 1'b1, 16'd16, 20'd100, 20'd0, 20'd0, 1'b1, 1'b1, 20'd96},
    '{1'b1, 1'b1, 1'b1, 16'd16, 20'd0, 20'd0, 20'd0, 1'b1, 1'b0, 20'd0},
    '{1'b1, 1'b1, 1'b1, 16'd16, 20'd1, 20'd0, 20'd0, 1'b1, 1'b0, 20'd0},
    '{1'b1, 1'b1, 1'b1, 16'd16, 20'hFFFFF, 20'd0, 20'd0, 1'b1, 1'b1, 20'hFFFF0},
    '{1'b1, 1'b1, 1'b1, 16'd16, 20'hFFFFF, 20'hFFFFF, 20'd0, 1'b1, 1'b0, 20'd0},
    // boundary equal to restored count is not enough
    '{1'b1, 1'b1, 1'b1, 16'd16, 20'd100, 20'd96, 20'd0, 1'b1, 1'b0, 20'd0},
    '{1'b1, 1'b1, 1'b1, 16'd16, 20'd100, 20'd95, 20'd0, 1'b1, 1'b1, 20'd96},
    '{1'b1, 1'b1, 1'b1, 16'd16, 20'd100, 20'd0, 20'd24, 1'b1, 1'b1, 20'd96},
    // lcm above the prompt
    '{1'b1, 1'b1, 1'b1, 16'd16, 20'd100, 20'd0, 20'd200, 1'b1, 1'b0, 20'd0},
    '{1'b1, 1'b1, 1'b1, 16'd16, 20'hFFFFF, 20'd0, 20'hFFFFF, 1'b1, 1'b0, 20'd0},
    '{1'b1, 1'b1, 1'b1, 16'd16, 20'hFFFFF, 20'd0, 20'h80000, 1'b1, 1'b1, 20'h80000},
    '{1'b1, 1'b1, 1'b1, 16'd16, 20'd1000, 20'd500, 20'd40, 1'b0, 1'b0, 20'd0},
    '{1'b1, 1'b1, 1'b1, 16'hFFFF, 20'hFFFFF, 20'd0, 20'd0, 1'b1, 1'b1, 20'hFFFF0},
    '{1'b1, 1'b1, 1'b1, 16'hFFFF, 20'hFFFFF, 20'd0, 20'hFFFFF, 1'b1, 1'b0, 20'd0},
    '{1'b1, 1'b1, 1'b1, 16'hFFFF, 20'hFFFFF, 20'd0, 20'd3, 1'b0, 1'b0, 20'd0},
    '{1'b1, 1'b1, 1'b1, 16'd1, 20'hFFFFF, 20'hFFFFD, 20'd0, 1'b1, 1'b1, 20'hFFFFE},
    '{1'b1, 1'b1, 1'b1, 16'd1, 20'd2, 20'd0, 20'd1, 1'b1, 1'b1, 20'd1},
    '{1'b1, 1'b1, 1'b1, 16'd1, 20'h12345, 20'd0, 20'hFFFF, 1'b0, 1'b0, 20'd0},
    // each enable alone blocks the checkpoint
    '{1'b0, 1'b1, 1'b1, 16'd16, 20'd100, 20'd0, 20'd0, 1'b1, 1'b0, 20'd0},
    '{1'b1, 1'b0, 1'b1, 16'd16, 20'd100, 20'd0, 20'd0, 1'b1, 1'b0, 20'd0},
    '{1'b1, 1'b1, 1'b0, 16'd16, 20'd100, 20'd0, 20'd0, 1'b1, 1'b0, 20'd0},
    '{1'b1, 1'b1, 1'b1, 16'd0, 20'd100, 20'd0, 20'd0, 1'b1, 1'b0, 20'd0},
    '{1'b1, 1'b1, 1'b1, 16'd16, 20'd100, 20'd0, 20'd0, 1'b1, 1'b1, 20'd96}
  };

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint unsigned euclid_gcd(longint unsigned a, longint unsigned b);
    longint unsigned r;
    while (b != 0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  // boundary = (prompt-1) rounded down to the block size, or to lcm(block, segment)
  function automatic checkpoint_t lcm_floor_boundary(token_t prompt, token_t restored,
                                                     token_t segment);
    checkpoint_t res;
    longint unsigned align;
    longint unsigned cand;
    res = '0;
    if (lookup_en && cache_en && reuse_mode && blk_tokens != 0 && prompt != 0) begin
      align = longint'(blk_tokens);
      if (segment != 0)
        align = align / euclid_gcd(longint'(blk_tokens), longint'(segment))
                * longint'(segment);
      cand = ((longint'(prompt) - 1) / align) * align;
      if (cand > longint'(restored)) begin
        res.valid = 1'b1;
        res.boundary = cand[TOKEN_BITS-1:0];
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatches++;
    $display("word %0d: %s got %h want %h", words_out, what, got, want);
  endtask

  // four back-to-back writes; flag registers get random upper bits that must be ignored
  task automatic write_settings(logic lk, logic co, logic md, block_t blk);
    logic [BLOCK_BITS-2:0] junk;
    junk = (BLOCK_BITS-1)'($urandom);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_LOOKUP;
    cfg_data_i <= {junk, lk};
    @(posedge clk_i);
    junk = (BLOCK_BITS-1)'($urandom);
    cfg_idx_i  <= CFG_CACHE;
    cfg_data_i <= {junk, co};
    @(posedge clk_i);
    junk = (BLOCK_BITS-1)'($urandom);
    cfg_idx_i  <= CFG_MODE;
    cfg_data_i <= {junk, md};
    @(posedge clk_i);
    cfg_idx_i  <= CFG_BLOCK;
    cfg_data_i <= blk;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    lookup_en  = lk;
    cache_en   = co;
    reuse_mode = md;
    blk_tokens = blk;
    settings_used++;
  endtask

  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (pending_checkpoints.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_request(token_t prompt, token_t restored, token_t segment,
                              logic typed, checkpoint_t typed_result);
    int gap;
    checkpoint_t entry;
    gap = tx_gaps ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= IN_W'({segment, restored, prompt});
    @(posedge clk_i);
    while (!(s_axis_tready_o && s_axis_tvalid_i)) @(posedge clk_i);
    words_in++;
    entry = typed ? typed_result : lcm_floor_boundary(prompt, restored, segment);
    pending_checkpoints = {pending_checkpoints, entry};
  endtask

  function automatic block_t pick_block_size();
    case ($urandom_range(0, 5))
      0:       return block_t'($urandom_range(1, 16));
      1:       return block_t'(1) << $urandom_range(0, BLOCK_BITS-1);
      2:       return block_t'($urandom);
      3:       return '1;
      4:       return block_t'($urandom_range(1, 300));
      default: return block_t'($urandom_range(1, 4096));
    endcase
  endfunction

  task automatic send_random_request();
    token_t prompt;
    token_t restored;
    token_t segment;
    checkpoint_t probe;
    case ($urandom_range(0, 9))
      0:       prompt = '0;
      1:       prompt = token_t'(1);
      2:       prompt = '1;
      3, 4:    prompt = token_t'($urandom_range(0, 2000));
      default: prompt = token_t'($urandom);
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2: segment = '0;
      3:       segment = token_t'($urandom_range(1, 64));
      4:       segment = token_t'(blk_tokens * $urandom_range(1, 8));
      5:       segment = token_t'($urandom_range(1, 4096));
      6:       segment = '1;
      default: segment = token_t'($urandom);
    endcase
    case ($urandom_range(0, 5))
      0:       restored = '0;
      1:       restored = token_t'($urandom);
      2:       restored = '1;
      3:       restored = token_t'($urandom_range(0, prompt));
      default: begin
        // land right around the boundary
        probe = lcm_floor_boundary(prompt, '0, segment);
        restored = probe.boundary + token_t'($urandom_range(0, 2)) - token_t'(1);
      end
    endcase
    send_request(prompt, restored, segment, 1'b0, '0);
  endtask

  // result side: random stalls, one long hold-off, field compare
  initial begin : take_results
    int gap;
    checkpoint_t want;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      gap = rx_gaps ? $urandom_range(0, 3) : 0;
      if (words_out == HOLD_AT) gap = HOLD_CYCLES;
      if (gap > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      @(posedge clk_i);
      while (!(m_axis_tvalid_o && m_axis_tready_i)) @(posedge clk_i);
      words_out++;
      if (m_axis_tuser_o) checkpoints_seen++;
      if (pending_checkpoints.size() == 0) begin
        report_mismatch("unexpected word", 32'(m_axis_tdata_o), 0);
      end else begin
        want = pending_checkpoints.pop_front();
        if (m_axis_tuser_o !== want.valid)
          report_mismatch("checkpoint_valid", 32'(m_axis_tuser_o), 32'(want.valid));
        if (m_axis_tdata_o[TOKEN_BITS-1:0] !== want.boundary)
          report_mismatch("boundary_tokens", 32'(m_axis_tdata_o[TOKEN_BITS-1:0]),
                          32'(want.boundary));
      end
    end
  end

  // watchdog on cycles with no handshake of any kind
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
          cfg_we_i || !rst_ni)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: %0d cycles without a word", IDLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin : stimulus
    dir_row_t row;
    logic lk;
    logic co;
    logic md;
    block_t blk;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.lookup != lookup_en || row.cache != cache_en || row.mode != reuse_mode ||
          row.blk != blk_tokens) begin
        drain_results();
        write_settings(row.lookup, row.cache, row.mode, row.blk);
      end
      send_request(row.prompt, row.restored, row.segment, row.typed,
                   {row.want_valid, row.want_boundary});
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      lk = ($urandom_range(0, 7) != 0);
      co = ($urandom_range(0, 7) != 0);
      md = ($urandom_range(0, 7) != 0);
      blk = pick_block_size();
      case (ph)
        0: begin lk = 1'b1; co = 1'b1; md = 1'b1; blk = 16'd1; end
        1: begin lk = 1'b1; co = 1'b1; md = 1'b1; blk = '1; end
        2: begin lk = 1'b1; co = 1'b1; md = 1'b1; blk = '0; end
        3: begin lk = 1'($urandom); co = 1'($urandom); md = 1'($urandom); end
        default: ;
      endcase
      tx_gaps = (ph % 4 != 1) && (ph % 4 != 3);
      rx_gaps = (ph % 4 != 2) && (ph % 4 != 3);
      drain_results();
      write_settings(lk, co, md, blk);
      repeat (PHASE_ITEMS) send_random_request();
    end

    drain_results();
    repeat (SETTLE) @(posedge clk_i);
    $display("%0d requests under %0d register settings, %0d words returned a checkpoint",
             words_in, settings_used, checkpoints_seen);
    if (mismatches == 0 && pending_checkpoints.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches,
               pending_checkpoints.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/clba_pkg.sv
hw/rtl/clba_alu.sv
hw/rtl/clba_seq.sv
hw/rtl/checkpoint_boundary_lcm_align.sv
hw/rtl/clba_chk.sv
test/checkpoint_boundary_lcm_align_tb.sv
